// File: design/modo_pkg.sv
package modo_pkg;

  // beat on the input channel
  typedef struct packed {
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic        [7:0]  motion_status;
    logic        [7:0]  surface_quality;
    logic        [7:0]  pixel_total;
  } in_beat_t;

  // beat on the output channel
  typedef struct packed {
    logic signed [31:0] distance_x_mm;
    logic signed [31:0] distance_y_mm;
    logic        [7:0]  status_out;
    logic        [7:0]  quality_out;
    logic        [7:0]  pixel_out;
  } out_beat_t;

  localparam int unsigned CpiW    = 14;
  localparam logic [CpiW-1:0] CpiReset = 14'd200;
  localparam int unsigned TotW    = 32;
  // |total| * 254 stays below 2^39
  localparam int unsigned NumW    = 40;
  // 10 * cpi stays below 2^18
  localparam int unsigned RemW    = 18;
  localparam int unsigned DigitW  = 2;
  localparam int unsigned DivSteps = NumW / DigitW;
  localparam int unsigned CntW    = $clog2(DivSteps);
  localparam logic [CntW-1:0] LastStep = CntW'(DivSteps - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ABS  = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

endpackage

// File: design/motion_odometer_mm.sv
// motion odometer: each input beat carries one motion report; the x and y counts are added
// to two wrapping 32-bit totals, and each total is turned into millimetres as
// total * 254 / (10 * counts_per_inch), truncated toward zero and saturated to 32 bits
// (a zero resolution gives zero distance). one shared radix-4 restoring divider handles
// x and then y, two quotient bits per cycle over a 40-bit dividend. from input accept to
// output valid a report passes, per axis, the magnitude and divisor state, the *254
// shift-subtract state, the divide steps and the sign and saturation state, and then
// the output-load state, after which the block is back in idle and can take the next
// report; a stalled output holds the block in the output-load state.
// one report is in flight at a time; a finished beat waits in the output register while
// the next report is taken in. the user must write counts_per_inch through cfg_we_i /
// cfg_data_i only while the block is idle; the block itself does not enforce this.
module motion_odometer_mm
  import modo_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_beat_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_beat_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [CpiW-1:0] cfg_data_i
);

  state_e            st_q, st_d;
  logic [CpiW-1:0]   cpi_q;
  logic [TotW-1:0]   tot_x_q, tot_y_q;
  logic [7:0]        stat_q, qual_q, pix_q;
  logic              axis_q;          // 0: x, 1: y
  logic              neg_q;
  logic [TotW-1:0]   mag_q;
  logic [NumW-1:0]   num_q;           // dividend, shifts into quotient
  logic [RemW-1:0]   rem_q;
  logic [RemW-1:0]   div_q;
  logic [CntW-1:0]   cnt_q;
  logic [TotW-1:0]   dx_q;
  logic [TotW-1:0]   res;
  logic              out_valid_q;
  out_beat_t         out_q;

  logic              in_fire;
  logic [TotW-1:0]   sel_tot;
  logic [RemW-1:0]   rem_nx;
  logic [NumW-1:0]   num_nx;

  assign in_ready_o  = (st_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign sel_tot     = axis_q ? tot_y_q : tot_x_q;

  // two restoring divide steps
  always_comb begin
    logic [RemW:0]   trial;
    logic [RemW-1:0] r;
    logic [NumW-1:0] n;
    r = rem_q;
    n = num_q;
    for (int i = 0; i < DigitW; i++) begin
      trial = {r, n[NumW-1]};
      n = {n[NumW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
        n[0] = 1'b1;
      end
      r = trial[RemW-1:0];
    end
    rem_nx = r;
    num_nx = n;
  end

  // sign, saturation and the zero-resolution case
  always_comb begin
    if (div_q == '0) begin
      res = '0;
    end else if (neg_q) begin
      if (num_q > NumW'(64'h8000_0000)) res = 32'h8000_0000;
      else res = -num_q[TotW-1:0];
    end else if (|num_q[NumW-1:TotW-1]) begin
      res = 32'h7fff_ffff;
    end else begin
      res = num_q[TotW-1:0];
    end
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (in_fire) st_d = S_ABS;
      S_ABS:  st_d = S_MUL;
      S_MUL:  st_d = S_DIV;
      S_DIV:  if (cnt_q == LastStep) st_d = S_FIN;
      S_FIN:  st_d = axis_q ? S_OUT : S_ABS;
      S_OUT:  if (!out_valid_q || out_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cpi_q       <= CpiReset;
      tot_x_q     <= '0;
      tot_y_q     <= '0;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) cpi_q <= cfg_data_i;
      // load wins over drain when a new beat replaces the one just taken
      if (st_q == S_OUT && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (in_fire) begin
            // running totals wrap mod 2^32
            tot_x_q <= tot_x_q + TotW'(signed'(in_data_i.move_x));
            tot_y_q <= tot_y_q + TotW'(signed'(in_data_i.move_y));
            axis_q  <= 1'b0;
          end
        end
        S_MUL:  cnt_q <= '0;
        S_DIV:  cnt_q <= cnt_q + 1'b1;
        S_FIN:  axis_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stat_q <= in_data_i.motion_status;
      qual_q <= in_data_i.surface_quality;
      pix_q  <= in_data_i.pixel_total;
    end
    case (st_q)
      S_ABS: begin
        neg_q <= sel_tot[TotW-1];
        mag_q <= sel_tot[TotW-1] ? -sel_tot : sel_tot;
        // 10 * cpi as 8 * cpi + 2 * cpi
        div_q <= {1'b0, cpi_q, 3'b000} + {3'b000, cpi_q, 1'b0};
      end
      S_MUL: begin
        // |total| * 254 as 256x - 2x
        num_q <= {mag_q, 8'h00} - {7'h00, mag_q, 1'b0};
        rem_q <= '0;
      end
      S_DIV: begin
        num_q <= num_nx;
        rem_q <= rem_nx;
      end
      S_FIN: if (!axis_q) dx_q <= res;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.distance_x_mm <= dx_q;
          out_q.distance_y_mm <= res;
          out_q.status_out    <= stat_q;
          out_q.quality_out   <= qual_q;
          out_q.pixel_out     <= pix_q;
        end
      end
      default: ;
    endcase
  end

  // y result is taken straight from the saturation logic at output load
  // num_q and neg_q still hold the y axis during S_OUT

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(st_q))
    else $error("sequencer state not one-hot");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV && div_q != '0) |-> rem_q < div_q)
    else $error("divider remainder not below divisor");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV && cnt_q == LastStep) |=> st_q == S_FIN)
    else $error("divider did not finish after last step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second report taken while one is in flight");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

// testbench for motion_odometer_mm
// motion reports go in through a queue-fed driver, and a scoreboard keeps its own x/y running
// totals to predict each millimetre beat. random wait states are drawn on both the input and
// output sides. the resolution register is only rewritten while the pipe is drained. the run
// ends with short bursts at the lowest resolutions, where the conversion is largest.
module tb_top;
  import modo_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;

  logic            clk_i = 1'b0;
  logic            rst_n = 1'b0;

  // input channel
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_beat_t        in_data  = '0;

  // output channel
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_beat_t       out_data;

  // resolution register
  logic            cfg_we   = 1'b0;
  logic [CpiW-1:0] cfg_data = '0;

  // handshake seen at the last rising edge, read by the falling-edge drivers
  logic            in_taken  = 1'b0;
  logic            out_taken = 1'b0;

  // stimulus and scoreboard state
  in_beat_t        report_q[$];
  out_beat_t       mm_expect_q[$];
  logic [31:0]     odo_x = '0;
  logic [31:0]     odo_y = '0;
  logic [CpiW-1:0] cpi_model = CpiReset;
  logic            idle_en = 1'b1;
  int unsigned     send_gap = 0;
  int unsigned     sink_hold = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     error_count = 0;

  motion_odometer_mm u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // total * 254 / (10 * cpi), truncated toward zero, clamped to 32 bits signed;
  // a zero resolution gives zero distance
  function automatic logic [31:0] mm_from_counts(input logic [31:0] total,
                                                 input logic [CpiW-1:0] cpi);
    longint divisor;
    longint quo;
    divisor = 64'sd10 * longint'(cpi);
    if (divisor == 0) begin
      quo = 0;
    end else begin
      quo = (longint'($signed(total)) * 64'sd254) / divisor;
      if (quo > 64'sd2147483647) quo = 64'sd2147483647;
      if (quo < -64'sd2147483648) quo = -64'sd2147483648;
    end
    return quo[31:0];
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // scoreboard: outgoing beat is checked before the incoming beat of the same edge
  // is predicted, so a beat can never be matched against its own expectation
  always @(posedge clk_i) begin : scoreboard
    out_beat_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (mm_expect_q.size() == 0) begin
          report_error("output beat with nothing expected");
        end else begin
          want = mm_expect_q.pop_front();
          check_field("distance_x_mm", out_data.distance_x_mm, want.distance_x_mm);
          check_field("distance_y_mm", out_data.distance_y_mm, want.distance_y_mm);
          check_field("status_out", 32'(out_data.status_out), 32'(want.status_out));
          check_field("quality_out", 32'(out_data.quality_out), 32'(want.quality_out));
          check_field("pixel_out", 32'(out_data.pixel_out), 32'(want.pixel_out));
        end
      end
      if (in_valid && in_ready) begin
        // running totals wrap modulo 2^32
        odo_x = odo_x + {{16{in_data.move_x[15]}}, in_data.move_x};
        odo_y = odo_y + {{16{in_data.move_y[15]}}, in_data.move_y};
        want.distance_x_mm = mm_from_counts(odo_x, cpi_model);
        want.distance_y_mm = mm_from_counts(odo_y, cpi_model);
        want.status_out    = in_data.motion_status;
        want.quality_out   = in_data.surface_quality;
        want.pixel_out     = in_data.pixel_total;
        mm_expect_q.push_back(want);
      end
    end
  end

  // handshake flags for the falling-edge processes
  always @(posedge clk_i) begin
    in_taken  <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
  end

  // watchdog: too long without any beat on either channel ends the run
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no beat for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input driver: valid stays up with a stable payload until the beat is taken,
  // then draws a random gap (none with wait states off) before the next report
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : report_driver
    logic     valid_next;
    in_beat_t data_next;
    valid_next = in_valid;
    data_next  = in_data;
    if (!rst_n) begin
      valid_next = 1'b0;
    end else if (!in_valid || in_taken) begin
      valid_next = 1'b0;
      // beat just went through, draw the gap before the next one
      if (in_valid) send_gap = idle_en ? $urandom_range(0, 3) : 0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (report_q.size() != 0) begin
        data_next  = report_q.pop_front();
        valid_next = 1'b1;
      end
    end
    in_valid <= valid_next;
    in_data  <= data_next;
  end

  // ---------------------------------------------------------------------------
  // output sink: after each beat draws a random stall (none with wait states off) that
  // starts counting once the next beat shows up, so back-pressure lands on a waiting result
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : mm_sink
    logic ready_next;
    ready_next = out_ready;
    if (!rst_n) begin
      ready_next = 1'b0;
    end else if (out_taken) begin
      sink_hold  = idle_en ? $urandom_range(0, 3) : 0;
      ready_next = (sink_hold == 0);
    end else if (!out_ready && out_valid) begin
      if (sink_hold > 0) begin
        sink_hold--;
      end else begin
        ready_next = 1'b1;
      end
    end
    out_ready <= ready_next;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic in_beat_t make_report(input int mx, input int my, input logic [7:0] st,
                                           input logic [7:0] sq, input logic [7:0] px);
    in_beat_t r;
    r.move_x          = mx[15:0];
    r.move_y          = my[15:0];
    r.motion_status   = st;
    r.surface_quality = sq;
    r.pixel_total     = px;
    return r;
  endfunction

  // mix of full-range, near-zero, extreme and single-axis motion
  function automatic in_beat_t random_report();
    in_beat_t r;
    int       vx;
    int       vy;
    vx = int'($urandom_range(0, 65535)) - 32768;
    vy = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 5))
      2, 3: begin
        vx = int'($urandom_range(0, 400)) - 200;
        vy = int'($urandom_range(0, 400)) - 200;
      end
      4: begin
        vx = $urandom_range(0, 1) ? 32767 : -32768;
        vy = $urandom_range(0, 1) ? 32767 : -32768;
      end
      5: begin
        if ($urandom_range(0, 1)) vx = 0;
        else vy = 0;
      end
      default: ;
    endcase
    r = make_report(vx, vy, 8'($urandom), 8'($urandom), 8'($urandom));
    return r;
  endfunction

  task automatic write_cpi(input logic [CpiW-1:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cpi_model  = value;
  endtask

  // wait until every report is sent and every result is back, then leave the channels quiet
  task automatic drain();
    do @(posedge clk_i);
    while (report_q.size() != 0 || in_valid || mm_expect_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [CpiW-1:0] cpi_pick;
    repeat (6) @(negedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed part, reset resolution of 200 first
    report_q.push_back(make_report(0, 0, 8'h00, 8'h00, 8'h00));
    // +8 gives +1 mm, -7 must truncate to 0 rather than floor to -1
    report_q.push_back(make_report(8, -7, 8'hff, 8'hff, 8'hff));
    report_q.push_back(make_report(32767, -32768, 8'h55, 8'haa, 8'h55));
    report_q.push_back(make_report(32767, -32768, 8'haa, 8'h55, 8'haa));
    report_q.push_back(make_report(-32768, 32767, 8'h01, 8'h80, 8'h7f));
    report_q.push_back(make_report(-32768, 32767, 8'h80, 8'h01, 8'hfe));
    drain();

    // zero resolution: distances read zero while totals keep counting
    write_cpi('0);
    report_q.push_back(make_report(100, -100, 8'h12, 8'h34, 8'h56));
    report_q.push_back(make_report(32767, -32768, 8'hff, 8'h00, 8'hff));
    drain();

    // resolutions below the normal range
    write_cpi(14'd1);
    report_q.push_back(make_report(-1, 1, 8'h00, 8'hff, 8'h00));
    report_q.push_back(make_report(32767, -32768, 8'h0f, 8'hf0, 8'h3c));
    drain();
    write_cpi(14'd49);
    report_q.push_back(make_report(-32768, 32767, 8'hc3, 8'h3c, 8'h99));
    drain();

    // range ends and the widest register value
    write_cpi(14'd50);
    report_q.push_back(make_report(1234, -1234, 8'h66, 8'h77, 8'h88));
    report_q.push_back(make_report(-5, 5, 8'h99, 8'haa, 8'hbb));
    drain();
    write_cpi(14'd8200);
    report_q.push_back(make_report(32767, 32767, 8'hcc, 8'hdd, 8'hee));
    report_q.push_back(make_report(-32768, -32768, 8'h11, 8'h22, 8'h33));
    drain();
    write_cpi(14'h3fff);
    report_q.push_back(make_report(32767, -32768, 8'h44, 8'h55, 8'h66));
    report_q.push_back(make_report(-1, -1, 8'h77, 8'h88, 8'h99));
    drain();

    // random part: five settings, one of them without any wait states
    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(0, 4))
        0: cpi_pick = 14'($urandom_range(50, 8200));
        1: cpi_pick = 14'($urandom_range(1, 49));
        2: cpi_pick = $urandom_range(0, 1) ? 14'h3fff : 14'd0;
        3: cpi_pick = 14'($urandom_range(0, 16383));
        default: cpi_pick = $urandom_range(0, 1) ? 14'd8200 : 14'd50;
      endcase
      write_cpi(cpi_pick);
      idle_en = (ph != 2);
      for (int n = 0; n < 240; n++) report_q.push_back(random_report());
      drain();
    end

    // a few more at the lowest resolutions, wait states on
    idle_en = 1'b1;
    write_cpi(14'($urandom_range(2, 12)));
    for (int n = 0; n < 20; n++) report_q.push_back(random_report());
    drain();
    write_cpi(14'd49);
    for (int n = 0; n < 20; n++) report_q.push_back(random_report());
    drain();

    repeat (60) @(posedge clk_i);
    if (mm_expect_q.size() != 0) report_error("results still expected at end of run");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
design/modo_pkg.sv
design/motion_odometer_mm.sv
test/tb_top.sv
